@@ sv/lslf_pkg.sv @@
// ----------------------------------------------------------------------------
// Least-squares line fit: shared package
// Widths, codes, interface structures and the quotient saturation function
// used by the fit datapath, the shared multiplier and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package lslf_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int MIN_SAMPLES = 2;
	localparam int X_BITS      = 24;
	localparam int SAMPLE_X_W  = 24;
	localparam int Y_BITS      = 32;
	localparam int LOG_MAX     = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int SX_W        = X_BITS + LOG_MAX;
	localparam int SY_W        = Y_BITS + LOG_MAX;
	localparam int SXY_W       = X_BITS + Y_BITS + LOG_MAX;
	localparam int SXX_W       = 2 * X_BITS + LOG_MAX;

	localparam int MUL_W       = 32;
	localparam int OPD_W       = 2 * MUL_W;
	localparam int ACC_W       = 128;
	localparam int DEN_W       = 64;
	localparam int SLOPE_W     = 64;
	localparam int ICPT_W      = 48;
	localparam int FRAC_W      = 16;

	localparam int N_PRODS     = 6;
	localparam int N_UOPS      = 4 * N_PRODS;
	localparam int UOP_W       = $clog2(N_UOPS + 1);
	localparam int PROD_W      = UOP_W - 2;
	localparam int DIV_CNT_W   = $clog2(ACC_W);

	localparam int ACC_N       = 3;
	localparam int ACC_IDX_W   = $clog2(ACC_N);

	typedef enum logic [1:0] {
		FIT_OK    = 2'd0,
		FIT_FEW   = 2'd1,
		FIT_DEGEN = 2'd2,
		FIT_OVF   = 2'd3
	} fit_status_t;

	localparam logic [ACC_IDX_W-1:0] ACC_DEN = ACC_IDX_W'(0);
	localparam logic [ACC_IDX_W-1:0] ACC_SN  = ACC_IDX_W'(1);
	localparam logic [ACC_IDX_W-1:0] ACC_IN  = ACC_IDX_W'(2);

	localparam logic [PROD_W-1:0] PR_N_SXX  = PROD_W'(0);
	localparam logic [PROD_W-1:0] PR_SX_SX  = PROD_W'(1);
	localparam logic [PROD_W-1:0] PR_N_SXY  = PROD_W'(2);
	localparam logic [PROD_W-1:0] PR_SX_SY  = PROD_W'(3);
	localparam logic [PROD_W-1:0] PR_SXX_SY = PROD_W'(4);
	localparam logic [PROD_W-1:0] PR_SX_SXY = PROD_W'(5);

	typedef struct packed {
		logic             en;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic                 vld;
		logic [ACC_IDX_W-1:0] dst;
		logic                 neg;
		logic [1:0]           shift;
	} mac_tag_t;

	// Applies the sign to a quotient magnitude and clamps it to a signed
	// field of the given width; the caller keeps the low bits it needs.
	function automatic logic [SLOPE_W-1:0] sat_quot(input logic [ACC_W-1:0] q,
			input logic neg, input int unsigned bits);
		logic [ACC_W-1:0] top;
		logic [ACC_W-1:0] v;
		top = ACC_W'(1) << (bits - 1);
		if (neg) begin
			v = (q > top) ? top : q;
			v = -v;
		end else begin
			v = (q > top - ACC_W'(1)) ? top - ACC_W'(1) : q;
		end
		return v[SLOPE_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/least_squares_line_fit_top.sv @@
// ----------------------------------------------------------------------------
// Least-squares line fit: top level
// Accumulates sample sums and, on the last word of a window, fits a line.
// ----------------------------------------------------------------------------
// Each sample word that fits in the window is taken in ST_IDLE and then
// passes through ST_MXY, ST_MXX and ST_AXX, in which the one shared 32 by 32
// multiplier forms x*y and x*x and adds them into the sums. The word marked
// last then starts the fit, during which no sample is taken: the ST_CHECK
// state, 24 partial products through the same multiplier plus a drain step,
// the ST_DEN test of the denominator, and two 128-step divisions on the
// bit-serial divider. A window that ends in overflow or with fewer than two
// samples finishes straight after ST_CHECK, and one with a zero denominator
// after ST_DEN. The result word sits in an output register, so sampling
// resumes while it waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module least_squares_line_fit_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   sample_valid,
	output logic                                        sample_ready,
	input  wire logic [lslf_pkg::SAMPLE_X_W-1:0]        sample_x,
	input  wire logic signed [lslf_pkg::Y_BITS-1:0]     sample_y,
	input  wire logic                                   last_sample,
	output logic                                        fit_valid,
	input  wire logic                                   fit_ready,
	output logic signed [lslf_pkg::SLOPE_W-1:0]         fit_slope,
	output logic signed [lslf_pkg::ICPT_W-1:0]          fit_intercept,
	output logic [1:0]                                  fit_status
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MXY   = 10'b0000000010,
		ST_MXX   = 10'b0000000100,
		ST_AXX   = 10'b0000001000,
		ST_CHECK = 10'b0000010000,
		ST_FIT   = 10'b0000100000,
		ST_DEN   = 10'b0001000000,
		ST_DIV_S = 10'b0010000000,
		ST_DIV_I = 10'b0100000000,
		ST_DONE  = 10'b1000000000
	} state_t;

	state_t                                state_q;
	logic [lslf_pkg::CNT_W-1:0]            count_q;
	logic [lslf_pkg::SX_W-1:0]             sx_q;
	logic signed [lslf_pkg::SY_W-1:0]      sy_q;
	logic signed [lslf_pkg::SXY_W-1:0]     sxy_q;
	logic [lslf_pkg::SXX_W-1:0]            sxx_q;
	logic                                  ovf_q;
	logic [lslf_pkg::UOP_W-1:0]            uop_q;
	lslf_pkg::mac_tag_t                    tag_s1;
	logic                                  out_valid_q;

	logic [lslf_pkg::X_BITS-1:0]           x_q;
	logic [lslf_pkg::Y_BITS-1:0]           ymag_q;
	logic                                  yneg_q;
	logic                                  last_q;
	logic [lslf_pkg::OPD_W-1:0]            mag_y_q;
	logic                                  neg_y_q;
	logic [lslf_pkg::OPD_W-1:0]            mag_xy_q;
	logic                                  neg_xy_q;
	logic [lslf_pkg::ACC_W-1:0]            acc_q [lslf_pkg::ACC_N];
	logic                                  slope_neg_q;
	logic                                  icpt_neg_q;
	logic [lslf_pkg::SLOPE_W-1:0]          res_slope_q;
	logic [lslf_pkg::ICPT_W-1:0]           res_icpt_q;
	lslf_pkg::fit_status_t                 res_status_q;
	logic [lslf_pkg::SLOPE_W-1:0]          out_slope_q;
	logic [lslf_pkg::ICPT_W-1:0]           out_icpt_q;
	lslf_pkg::fit_status_t                 out_status_q;

	logic                                  accept;
	logic                                  sample_full;
	logic [lslf_pkg::X_BITS-1:0]           x_in;
	logic [lslf_pkg::Y_BITS-1:0]           y_in_mag;
	logic [2*lslf_pkg::MUL_W-1:0]          prod_q;
	lslf_pkg::mul_req_t                    mul_req;
	lslf_pkg::div_req_t                    div_req;
	lslf_pkg::div_stat_t                   div_stat;
	logic [lslf_pkg::ACC_W-1:0]            quot;
	logic [lslf_pkg::SXY_W-1:0]            xy_ext;
	logic signed [lslf_pkg::OPD_W-1:0]     sy_ext;
	logic signed [lslf_pkg::OPD_W-1:0]     sxy_ext;

	logic                                  issue;
	logic [lslf_pkg::PROD_W-1:0]           uop_prod;
	logic                                  uop_ai;
	logic                                  uop_bi;
	logic [lslf_pkg::OPD_W-1:0]            opd_a;
	logic [lslf_pkg::OPD_W-1:0]            opd_b;
	logic [lslf_pkg::ACC_IDX_W-1:0]        uop_dst;
	logic                                  uop_neg;
	logic [lslf_pkg::ACC_W-1:0]            pp_ext;
	logic [lslf_pkg::ACC_W-1:0]            pp_shifted;
	logic [lslf_pkg::ACC_W-1:0]            addend;
	logic [lslf_pkg::ACC_W-1:0]            acc_sum;

	logic [lslf_pkg::ACC_W-1:0]            den_full;
	logic                                  den_zero;
	logic [lslf_pkg::ACC_W-1:0]            sh_num;
	logic [lslf_pkg::ACC_W-1:0]            sh_mag;
	logic [lslf_pkg::ACC_W-1:0]            in_num;
	logic [lslf_pkg::ACC_W-1:0]            in_mag;
	logic                                  out_load;

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign sample_full  = (count_q >= lslf_pkg::CNT_W'(lslf_pkg::MAX_SAMPLES));
	assign x_in         = sample_x[lslf_pkg::X_BITS-1:0];
	assign y_in_mag     = sample_y[lslf_pkg::Y_BITS-1] ? -sample_y : sample_y;
	assign xy_ext       = lslf_pkg::SXY_W'(prod_q[lslf_pkg::X_BITS+lslf_pkg::Y_BITS-1:0]);
	assign sy_ext       = lslf_pkg::OPD_W'(sy_q);
	assign sxy_ext      = lslf_pkg::OPD_W'(sxy_q);

	assign issue    = (state_q == ST_FIT) && (uop_q < lslf_pkg::UOP_W'(lslf_pkg::N_UOPS));
	assign uop_prod = uop_q[lslf_pkg::UOP_W-1:2];
	assign uop_ai   = uop_q[1];
	assign uop_bi   = uop_q[0];

	// Each fit term is a product of two magnitudes of up to 64 bits, taken as
	// four 32-bit partial products and added into one of three accumulators.
	always_comb begin
		opd_a   = '0;
		opd_b   = '0;
		uop_dst = lslf_pkg::ACC_DEN;
		uop_neg = 1'b0;
		unique case (uop_prod)
			lslf_pkg::PR_N_SXX: begin
				opd_a   = lslf_pkg::OPD_W'(count_q);
				opd_b   = lslf_pkg::OPD_W'(sxx_q);
				uop_dst = lslf_pkg::ACC_DEN;
			end
			lslf_pkg::PR_SX_SX: begin
				opd_a   = lslf_pkg::OPD_W'(sx_q);
				opd_b   = lslf_pkg::OPD_W'(sx_q);
				uop_dst = lslf_pkg::ACC_DEN;
				uop_neg = 1'b1;
			end
			lslf_pkg::PR_N_SXY: begin
				opd_a   = lslf_pkg::OPD_W'(count_q);
				opd_b   = mag_xy_q;
				uop_dst = lslf_pkg::ACC_SN;
				uop_neg = neg_xy_q;
			end
			lslf_pkg::PR_SX_SY: begin
				opd_a   = lslf_pkg::OPD_W'(sx_q);
				opd_b   = mag_y_q;
				uop_dst = lslf_pkg::ACC_SN;
				uop_neg = !neg_y_q;
			end
			lslf_pkg::PR_SXX_SY: begin
				opd_a   = lslf_pkg::OPD_W'(sxx_q);
				opd_b   = mag_y_q;
				uop_dst = lslf_pkg::ACC_IN;
				uop_neg = neg_y_q;
			end
			lslf_pkg::PR_SX_SXY: begin
				opd_a   = lslf_pkg::OPD_W'(sx_q);
				opd_b   = mag_xy_q;
				uop_dst = lslf_pkg::ACC_IN;
				uop_neg = !neg_xy_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mul_req = '0;
		if (state_q == ST_MXY) begin
			mul_req.en = 1'b1;
			mul_req.a  = lslf_pkg::MUL_W'(x_q);
			mul_req.b  = ymag_q;
		end else if (state_q == ST_MXX) begin
			mul_req.en = 1'b1;
			mul_req.a  = lslf_pkg::MUL_W'(x_q);
			mul_req.b  = lslf_pkg::MUL_W'(x_q);
		end else if (issue) begin
			mul_req.en = 1'b1;
			mul_req.a  = uop_ai ? opd_a[lslf_pkg::OPD_W-1:lslf_pkg::MUL_W]
				: opd_a[lslf_pkg::MUL_W-1:0];
			mul_req.b  = uop_bi ? opd_b[lslf_pkg::OPD_W-1:lslf_pkg::MUL_W]
				: opd_b[lslf_pkg::MUL_W-1:0];
		end
	end

	lslf_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod_q)
	);

	assign pp_ext = lslf_pkg::ACC_W'(prod_q);

	always_comb begin
		unique case (tag_s1.shift)
			2'd0:    pp_shifted = pp_ext;
			2'd1:    pp_shifted = pp_ext << lslf_pkg::MUL_W;
			2'd2:    pp_shifted = pp_ext << (2 * lslf_pkg::MUL_W);
			default: pp_shifted = '0;
		endcase
	end

	assign addend  = tag_s1.neg ? ~pp_shifted : pp_shifted;
	assign acc_sum = acc_q[tag_s1.dst] + addend + lslf_pkg::ACC_W'(tag_s1.neg);

	assign den_full = acc_q[lslf_pkg::ACC_DEN];
	assign den_zero = (den_full == '0);
	assign sh_num   = acc_q[lslf_pkg::ACC_SN] << lslf_pkg::FRAC_W;
	assign sh_mag   = sh_num[lslf_pkg::ACC_W-1] ? -sh_num : sh_num;
	assign in_num   = acc_q[lslf_pkg::ACC_IN];
	assign in_mag   = in_num[lslf_pkg::ACC_W-1] ? -in_num : in_num;

	always_comb begin
		div_req.start = ((state_q == ST_DEN) && !den_zero) ||
			((state_q == ST_DIV_S) && div_stat.done);
		div_req.num   = (state_q == ST_DEN) ? sh_mag : in_mag;
		div_req.den   = den_full[lslf_pkg::DEN_W-1:0];
	end

	lslf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat),
		.quot   (quot)
	);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || fit_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			sxy_q       <= '0;
			sxx_q       <= '0;
			ovf_q       <= 1'b0;
			uop_q       <= '0;
			tag_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			tag_s1 <= '{vld: issue, dst: uop_dst, neg: uop_neg,
				shift: {1'b0, uop_ai} + {1'b0, uop_bi}};
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (fit_valid && fit_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sample_full) begin
							ovf_q   <= 1'b1;
							state_q <= last_sample ? ST_CHECK : ST_IDLE;
						end else begin
							count_q <= count_q + lslf_pkg::CNT_W'(1);
							sx_q    <= sx_q + lslf_pkg::SX_W'(x_in);
							sy_q    <= sy_q + lslf_pkg::SY_W'(sample_y);
							state_q <= ST_MXY;
						end
					end
				end
				ST_MXY: begin
					state_q <= ST_MXX;
				end
				ST_MXX: begin
					sxy_q   <= yneg_q ? sxy_q - xy_ext : sxy_q + xy_ext;
					state_q <= ST_AXX;
				end
				ST_AXX: begin
					sxx_q   <= sxx_q + lslf_pkg::SXX_W'(prod_q[2*lslf_pkg::X_BITS-1:0]);
					state_q <= last_q ? ST_CHECK : ST_IDLE;
				end
				ST_CHECK: begin
					uop_q <= '0;
					if (ovf_q || count_q < lslf_pkg::CNT_W'(lslf_pkg::MIN_SAMPLES)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_FIT;
					end
				end
				ST_FIT: begin
					if (issue) begin
						uop_q <= uop_q + lslf_pkg::UOP_W'(1);
					end else begin
						state_q <= ST_DEN;
					end
				end
				ST_DEN: begin
					state_q <= den_zero ? ST_DONE : ST_DIV_S;
				end
				ST_DIV_S: begin
					if (div_stat.done) begin
						state_q <= ST_DIV_I;
					end
				end
				ST_DIV_I: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						count_q     <= '0;
						sx_q        <= '0;
						sy_q        <= '0;
						sxy_q       <= '0;
						sxx_q       <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= x_in;
			ymag_q <= y_in_mag;
			yneg_q <= sample_y[lslf_pkg::Y_BITS-1];
			last_q <= last_sample;
		end
		if (state_q == ST_CHECK) begin
			mag_y_q  <= sy_q[lslf_pkg::SY_W-1] ? -sy_ext : sy_ext;
			neg_y_q  <= sy_q[lslf_pkg::SY_W-1];
			mag_xy_q <= sxy_q[lslf_pkg::SXY_W-1] ? -sxy_ext : sxy_ext;
			neg_xy_q <= sxy_q[lslf_pkg::SXY_W-1];
			for (int i = 0; i < lslf_pkg::ACC_N; i++) begin
				acc_q[i] <= '0;
			end
			res_slope_q  <= '0;
			res_icpt_q   <= '0;
			res_status_q <= ovf_q ? lslf_pkg::FIT_OVF : lslf_pkg::FIT_FEW;
		end
		if (tag_s1.vld) begin
			acc_q[tag_s1.dst] <= acc_sum;
		end
		if (state_q == ST_DEN) begin
			slope_neg_q  <= sh_num[lslf_pkg::ACC_W-1];
			icpt_neg_q   <= in_num[lslf_pkg::ACC_W-1];
			res_status_q <= den_zero ? lslf_pkg::FIT_DEGEN : lslf_pkg::FIT_OK;
		end
		if (state_q == ST_DIV_S && div_stat.done) begin
			res_slope_q <= lslf_pkg::sat_quot(quot, slope_neg_q, lslf_pkg::SLOPE_W);
		end
		if (state_q == ST_DIV_I && div_stat.done) begin
			res_icpt_q <= lslf_pkg::ICPT_W'(lslf_pkg::sat_quot(quot, icpt_neg_q,
				lslf_pkg::ICPT_W));
		end
		if (out_load) begin
			out_slope_q  <= res_slope_q;
			out_icpt_q   <= res_icpt_q;
			out_status_q <= res_status_q;
		end
	end

	assign fit_valid     = out_valid_q;
	assign fit_slope     = out_slope_q;
	assign fit_intercept = out_icpt_q;
	assign fit_status    = out_status_q;

	// The window never holds more samples than it may.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lslf_pkg::CNT_W'(lslf_pkg::MAX_SAMPLES))
		else $error("sample count beyond the window limit");

	// The divider is only restarted once the previous division has finished.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_stat.busy)
		else $error("divider started while busy");

	// The fit denominator is a sum of squares and cannot be negative.
	a_den_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEN) |-> !den_full[lslf_pkg::ACC_W-1])
		else $error("negative fit denominator");

	// Partial products are only ever in flight during the fit sequence.
	a_tag_fit: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.vld |-> (state_q == ST_FIT))
		else $error("partial product outside the fit sequence");

	// A result word only appears after the sequencer has reached its end.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result word raised outside the final state");

endmodule

`default_nettype wire

@@ sv/lslf_mul.sv @@
// ----------------------------------------------------------------------------
// Least-squares line fit: shared multiplier
// One unsigned 32 by 32 multiplier with a registered product, used for the
// per-sample products and for every partial product of the fit.
// ----------------------------------------------------------------------------
`default_nettype none

module lslf_mul (
	input  wire logic                               clk,
	input  wire lslf_pkg::mul_req_t                 req,
	output logic [2*lslf_pkg::MUL_W-1:0]            prod_q
);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.a * req.b;
		end
	end

endmodule

`default_nettype wire

@@ sv/lslf_div.sv @@
// ----------------------------------------------------------------------------
// Least-squares line fit: restoring divider
// Unsigned 128 by 64 bit division, one quotient bit per cycle. The dividend
// register shifts out its top bit as each quotient bit shifts in.
// ----------------------------------------------------------------------------
`default_nettype none

module lslf_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lslf_pkg::div_req_t            req,
	output lslf_pkg::div_stat_t                stat,
	output logic [lslf_pkg::ACC_W-1:0]         quot
);

	logic [lslf_pkg::ACC_W-1:0]     num_q;
	logic [lslf_pkg::DEN_W-1:0]     rem_q;
	logic [lslf_pkg::DEN_W-1:0]     den_q;
	logic [lslf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [lslf_pkg::DEN_W:0]       trial;
	logic [lslf_pkg::DEN_W:0]       diff;
	logic                           fits;

	assign trial = {rem_q, num_q[lslf_pkg::ACC_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + lslf_pkg::DIV_CNT_W'(1);
				if (cnt_q == lslf_pkg::DIV_CNT_W'(lslf_pkg::ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[lslf_pkg::ACC_W-2:0], fits};
			rem_q <= fits ? diff[lslf_pkg::DEN_W-1:0] : trial[lslf_pkg::DEN_W-1:0];
		end
	end

	assign stat = '{busy: busy_q, done: done_q};
	assign quot = num_q;

endmodule

`default_nettype wire

@@ dv/lslf_fit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Least-squares line fit: result checker
// Watches both channels, keeps its own window sums, predicts the fit for
// every window closed by a last sample word and compares each result word
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module lslf_fit_checker
	import lslf_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	input  wire logic                          sample_ready,
	input  wire logic [SAMPLE_X_W-1:0]         sample_x,
	input  wire logic signed [Y_BITS-1:0]      sample_y,
	input  wire logic                          last_sample,
	input  wire logic                          fit_valid,
	input  wire logic                          fit_ready,
	input  wire logic signed [SLOPE_W-1:0]     fit_slope,
	input  wire logic signed [ICPT_W-1:0]      fit_intercept,
	input  wire logic [1:0]                    fit_status,
	output int                                 fails,
	output int                                 outstanding
);

	typedef struct packed {
		logic signed [SLOPE_W-1:0] slope;
		logic signed [ICPT_W-1:0]  intercept;
		fit_status_t               status;
	} fit_word_t;

	fit_word_t                 pending_fits[$];
	fit_word_t                 want;
	int                        win_count;
	logic [SX_W-1:0]           win_sx;
	logic signed [SY_W-1:0]    win_sy;
	logic signed [SXY_W-1:0]   win_sxy;
	logic [SXX_W-1:0]          win_sxx;
	bit                        win_ovf;

	initial begin
		fails = 0;
		outstanding = 0;
	end

	function automatic void clear_window();
		win_count = 0;
		win_sx = '0;
		win_sy = '0;
		win_sxy = '0;
		win_sxx = '0;
		win_ovf = 1'b0;
	endfunction

	function automatic logic signed [63:0] clamp_quotient(input logic signed [127:0] q,
			input int bits);
		logic signed [127:0] lim;
		lim = 128'sd1 <<< (bits - 1);
		if (q >= lim)
			q = lim - 128'sd1;
		else if (q < -lim)
			q = -lim;
		return q[63:0];
	endfunction

	function automatic fit_word_t fit_line();
		fit_word_t           r;
		logic signed [127:0] n_w;
		logic signed [127:0] sx_w;
		logic signed [127:0] sy_w;
		logic signed [127:0] sxy_w;
		logic signed [127:0] sxx_w;
		logic signed [127:0] den;
		logic signed [127:0] slope_num;
		logic signed [127:0] icpt_num;
		logic signed [63:0]  icpt_full;
		r.slope = '0;
		r.intercept = '0;
		n_w = 128'(win_count);
		sx_w = {{(128 - SX_W){1'b0}}, win_sx};
		sy_w = 128'(win_sy);
		sxy_w = 128'(win_sxy);
		sxx_w = {{(128 - SXX_W){1'b0}}, win_sxx};
		den = n_w * sxx_w - sx_w * sx_w;
		if (win_ovf) begin
			r.status = FIT_OVF;
		end else if (win_count < MIN_SAMPLES) begin
			r.status = FIT_FEW;
		end else if (den == 0) begin
			r.status = FIT_DEGEN;
		end else begin
			r.status = FIT_OK;
			slope_num = (n_w * sxy_w - sx_w * sy_w) * 128'sd65536;
			icpt_num = sxx_w * sy_w - sx_w * sxy_w;
			r.slope = clamp_quotient(slope_num / den, SLOPE_W);
			icpt_full = clamp_quotient(icpt_num / den, ICPT_W);
			r.intercept = icpt_full[ICPT_W-1:0];
		end
		return r;
	endfunction

	function automatic void absorb_sample(input logic [SAMPLE_X_W-1:0] x,
			input logic signed [Y_BITS-1:0] y, input logic last);
		if (win_count >= MAX_SAMPLES) begin
			win_ovf = 1'b1;
		end else begin
			win_count++;
			win_sx += x;
			win_sy += y;
			win_sxy += $signed({1'b0, x}) * y;
			win_sxx += x * x;
		end
		if (last) begin
			pending_fits.push_back(fit_line());
			clear_window();
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_window();
			pending_fits.delete();
		end else begin
			if (sample_valid && sample_ready)
				absorb_sample(sample_x, sample_y, last_sample);
			if (fit_valid && fit_ready) begin
				if (pending_fits.size() == 0) begin
					fails++;
					$display("%0t: unexpected fit word: expected none, got slope %0d intercept %0d status %0d",
						$time, fit_slope, fit_intercept, fit_status);
				end else begin
					want = pending_fits.pop_front();
					if (fit_slope !== want.slope) begin
						fails++;
						$display("%0t: fit_slope expected %0d, got %0d",
							$time, want.slope, fit_slope);
					end
					if (fit_intercept !== want.intercept) begin
						fails++;
						$display("%0t: fit_intercept expected %0d, got %0d",
							$time, want.intercept, fit_intercept);
					end
					if (fit_status !== want.status) begin
						fails++;
						$display("%0t: fit_status expected %0d, got %0d",
							$time, want.status, fit_status);
					end
				end
			end
		end
		outstanding <= pending_fits.size();
	end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Least-squares line fit: testbench top
// Drives sample windows into the fit block, first a few hand-picked windows
// and then random ones under changing amounts of idling and back-pressure,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------

module tb;

	import lslf_pkg::*;

	localparam int HOLD_CYCLES    = 1500;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 400;
	localparam int PHASE_WORDS    = 112;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        sample_valid = 1'b0;
	logic                        sample_ready;
	logic [SAMPLE_X_W-1:0]       sample_x = '0;
	logic signed [Y_BITS-1:0]    sample_y = '0;
	logic                        last_sample = 1'b0;
	logic                        fit_valid;
	logic                        fit_ready = 1'b0;
	logic signed [SLOPE_W-1:0]   fit_slope;
	logic signed [ICPT_W-1:0]    fit_intercept;
	logic [1:0]                  fit_status;

	int  fails;
	int  outstanding;
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_req = 1'b0;
	bit  hold_ack = 1'b0;
	int  hold_left = 0;
	int  quiet_cycles = 0;
	int  words_sent = 0;
	int  idle_set[4] = '{0, 72, 0, 23};
	int  stall_set[4] = '{0, 0, 72, 23};

	always #5 clk = ~clk;

	least_squares_line_fit_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.sample_x      (sample_x),
		.sample_y      (sample_y),
		.last_sample   (last_sample),
		.fit_valid     (fit_valid),
		.fit_ready     (fit_ready),
		.fit_slope     (fit_slope),
		.fit_intercept (fit_intercept),
		.fit_status    (fit_status)
	);

	lslf_fit_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.sample_x      (sample_x),
		.sample_y      (sample_y),
		.last_sample   (last_sample),
		.fit_valid     (fit_valid),
		.fit_ready     (fit_ready),
		.fit_slope     (fit_slope),
		.fit_intercept (fit_intercept),
		.fit_status    (fit_status),
		.fails         (fails),
		.outstanding   (outstanding)
	);

	// A long hold-off lets the output register and the fit engine fill up,
	// so that the block has to refuse further sample words.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			fit_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			fit_ready <= 1'b0;
		end else begin
			fit_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (fit_valid && fit_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [SAMPLE_X_W-1:0] pick_x();
		case ($urandom_range(3))
			0: return SAMPLE_X_W'($urandom);
			1: return SAMPLE_X_W'($urandom_range(255));
			2: return {SAMPLE_X_W{1'b1}} - SAMPLE_X_W'($urandom_range(255));
			default: return SAMPLE_X_W'($urandom_range(4095));
		endcase
	endfunction

	function automatic logic signed [Y_BITS-1:0] pick_y();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(2000) - 1000;
			2: return 32'h7FFFFFFF - $urandom_range(255);
			default: return 32'h80000000 + $urandom_range(255);
		endcase
	endfunction

	task automatic send_word(input logic [SAMPLE_X_W-1:0] x,
			input logic signed [Y_BITS-1:0] y, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_x <= x;
		sample_y <= y;
		last_sample <= last;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_window(input int len, input bit same_x);
		logic [SAMPLE_X_W-1:0] x0;
		x0 = pick_x();
		for (int k = 0; k < len; k++)
			send_word(same_x ? x0 : pick_x(), pick_y(), k == len - 1);
	endtask

	task automatic random_window();
		int roll;
		roll = $urandom_range(99);
		if (roll < 8)
			send_window(1, 1'b0);
		else if (roll < 11)
			send_window($urandom_range(MAX_SAMPLES, MAX_SAMPLES + 3), 1'b0);
		else if (roll < 25)
			send_window($urandom_range(2, 6), 1'b1);
		else
			send_window($urandom_range(2, 10), 1'b0);
	endtask

	initial begin
		int target;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A lone word, a window with one x, full-range extremes and both
		// directions of intercept saturation.
		send_word(24'd5, 32'sd100, 1'b1);
		send_word(24'hFFFFFF, 32'sh7FFFFFFF, 1'b0);
		send_word(24'hFFFFFF, -32'sd1, 1'b1);
		send_word(24'h000000, 32'sh7FFFFFFF, 1'b0);
		send_word(24'hFFFFFF, 32'sh80000000, 1'b1);
		send_word(24'h555555, 32'sh55555555, 1'b0);
		send_word(24'hAAAAAA, 32'shAAAAAAAA, 1'b0);
		send_word(24'h000000, 32'sh00000000, 1'b1);
		send_word(24'hFFFFFE, 32'sh80000000, 1'b0);
		send_word(24'hFFFFFF, 32'sh7FFFFFFF, 1'b1);
		send_word(24'hFFFFFE, 32'sh7FFFFFFF, 1'b0);
		send_word(24'hFFFFFF, 32'sh80000000, 1'b1);

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_set[p];
			stall_pct <= stall_set[p];
			target = words_sent + PHASE_WORDS;
			if (p == 0) begin
				hold_req <= ~hold_req;
				repeat (8) send_window(2, 1'b0);
			end
			if (p == 1)
				send_window(MAX_SAMPLES + 1, 1'b0);
			while (words_sent < target)
				random_window();
		end

		sample_valid <= 1'b0;
		// The checker's count of pending fits is a registered copy of its queue size.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
